// ===== rtl/kvt_pkg.sv =====
// ----------------------------------------------------------------------------
// kvt_pkg
// Shared types and constants of the key/value table: operation and status
// codes, table size and the item token that walks the cell row.
// ----------------------------------------------------------------------------
package kvt_pkg;

  // Table size and field widths
  localparam int ENTRIES   = 16;
  localparam int KEY_W     = 32;
  localparam int VAL_W     = 32;
  localparam int MODE_W    = 2;
  localparam int STAT_W    = 2;
  localparam int OUT_CNT_W = 5;
  localparam int CNT_W     = $clog2(ENTRIES + 1);

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  // Value reported when nothing was found
  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  // Item token handed from cell to cell.
  // claim: second pass of an insert, lowest free cell takes the pair.
  // hit:   some cell so far matched (search) or took the pair (claim).
  // free:  some cell so far was empty.
  typedef struct packed {
    logic              vld;
    logic [MODE_W-1:0] mode;
    logic              claim;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
    logic              hit;
    logic              free;
  } kvt_tok_t;

endpackage

// ===== rtl/kvt_cell.sv =====
// ----------------------------------------------------------------------------
// kvt_cell
// One table entry. Holds a key, a value and a valid bit, acts on the item
// token as it passes and hands the token to the next cell in the following cycle.
// ----------------------------------------------------------------------------
module kvt_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  kvt_pkg::kvt_tok_t tok_i,
  output kvt_pkg::kvt_tok_t tok_o
);

  logic [kvt_pkg::KEY_W-1:0] key_r;
  logic [kvt_pkg::VAL_W-1:0] value_r;
  logic                      valid_r, valid_nxt;
  kvt_pkg::kvt_tok_t         tok_r, tok_nxt;
  logic                      match;
  logic                      take;
  logic                      wr_key;
  logic                      wr_val;

  // Compare and act on the passing token
  always_comb begin
    match     = tok_i.vld && !tok_i.claim && valid_r && (key_r == tok_i.key);
    take      = 1'b0;
    wr_key    = 1'b0;
    wr_val    = 1'b0;
    valid_nxt = valid_r;
    tok_nxt   = tok_i;
    if (tok_i.vld) begin
      case (tok_i.mode)
        kvt_pkg::MODE_INSERT: begin
          if (tok_i.claim) begin
            take = !valid_r && !tok_i.hit;
            if (take) begin
              wr_key    = 1'b1;
              wr_val    = 1'b1;
              valid_nxt = 1'b1;
            end
          end else if (match) begin
            wr_val = 1'b1;
          end
        end
        kvt_pkg::MODE_LOOKUP: begin
          if (match) tok_nxt.value = value_r;
        end
        kvt_pkg::MODE_REMOVE: begin
          if (match) valid_nxt = 1'b0;
        end
        default: begin
          valid_nxt = 1'b0;
        end
      endcase
      tok_nxt.hit  = tok_i.hit | match | take;
      tok_nxt.free = tok_i.free | !valid_r;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      tok_r   <= tok_nxt;
    end
  end

  // Entry payload
  always_ff @(posedge clk) begin
    if (wr_key) key_r <= tok_i.key;
    if (wr_val) value_r <= tok_i.value;
  end

  assign tok_o = tok_r;

endmodule

// ===== rtl/key_value_table_unit.sv =====
// ----------------------------------------------------------------------------
// key_value_table_unit
// Associative key/value table built as a row of entry cells with a small
// controller that launches each item into the row and forms its result.
// ----------------------------------------------------------------------------
// One item is in the table at a time. On acceptance the item becomes a token
// that walks the row of ENTRIES cells, one cell per cycle; the result is formed
// when the token leaves the last cell. A lookup, remove, clear or update of a
// present key, or an insert into a full table, makes one walk. An insert of a
// new key into a table with room makes a second walk in which the lowest free
// cell takes the pair. in_stall is high from acceptance until the result has
// been taken. Every item gives one result.
// ----------------------------------------------------------------------------
module key_value_table_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [kvt_pkg::MODE_W-1:0]         in_mode,
  input  logic signed [kvt_pkg::KEY_W-1:0]   in_key,
  input  logic signed [kvt_pkg::VAL_W-1:0]   in_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [kvt_pkg::STAT_W-1:0]         out_status,
  output logic signed [kvt_pkg::VAL_W-1:0]   out_found_value,
  output logic [kvt_pkg::OUT_CNT_W-1:0]      out_entry_count
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_CLAIM  = 2'd2;
  localparam logic [1:0] S_RESULT = 2'd3;

  logic [1:0]                    state_r, state_nxt;
  kvt_pkg::kvt_tok_t             inj_r, inj_nxt;
  logic [kvt_pkg::CNT_W-1:0]     count_r, count_nxt;
  logic [kvt_pkg::STAT_W-1:0]    status_r, status_nxt;
  logic [kvt_pkg::VAL_W-1:0]     found_r, found_nxt;
  kvt_pkg::kvt_tok_t             tok_w [0:kvt_pkg::ENTRIES];
  logic [kvt_pkg::ENTRIES:0]     tok_vld_w;
  kvt_pkg::kvt_tok_t             tail;
  logic                          in_acc;
  logic                          out_acc;

  // Cell row
  assign tok_w[0] = inj_r;

  genvar g;
  generate
    for (g = 0; g < kvt_pkg::ENTRIES; g++) begin : g_cell
      kvt_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .tok_i (tok_w[g]),
        .tok_o (tok_w[g+1])
      );
    end
    for (g = 0; g <= kvt_pkg::ENTRIES; g++) begin : g_vld
      assign tok_vld_w[g] = tok_w[g].vld;
    end
  endgenerate

  assign tail    = tok_w[kvt_pkg::ENTRIES];
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // Controller: launch tokens, collect the token at the row end
  always_comb begin
    state_nxt  = state_r;
    inj_nxt    = '0;
    count_nxt  = count_r;
    status_nxt = status_r;
    found_nxt  = found_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          inj_nxt.vld   = 1'b1;
          inj_nxt.mode  = in_mode;
          inj_nxt.key   = in_key;
          inj_nxt.value = in_value;
          state_nxt     = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (tail.vld) begin
          status_nxt = kvt_pkg::ST_OK;
          found_nxt  = kvt_pkg::MISS_VALUE;
          state_nxt  = S_RESULT;
          case (tail.mode)
            kvt_pkg::MODE_INSERT: begin
              if (!tail.hit && tail.free) begin
                // new key with room: second walk to place it
                inj_nxt.vld   = 1'b1;
                inj_nxt.mode  = kvt_pkg::MODE_INSERT;
                inj_nxt.claim = 1'b1;
                inj_nxt.key   = tail.key;
                inj_nxt.value = tail.value;
                state_nxt     = S_CLAIM;
              end else if (!tail.hit) begin
                status_nxt = kvt_pkg::ST_FULL;
              end
            end
            kvt_pkg::MODE_LOOKUP: begin
              if (tail.hit) found_nxt = tail.value;
              else          status_nxt = kvt_pkg::ST_MISS;
            end
            kvt_pkg::MODE_REMOVE: begin
              if (tail.hit) count_nxt = count_r - kvt_pkg::CNT_W'(1);
              else          status_nxt = kvt_pkg::ST_MISS;
            end
            default: begin
              count_nxt = '0;
            end
          endcase
        end
      end
      S_CLAIM: begin
        if (tail.vld) begin
          count_nxt  = count_r + kvt_pkg::CNT_W'(1);
          status_nxt = kvt_pkg::ST_OK;
          found_nxt  = kvt_pkg::MISS_VALUE;
          state_nxt  = S_RESULT;
        end
      end
      default: begin
        if (out_acc) state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      inj_r   <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      inj_r   <= inj_nxt;
      count_r <= count_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    found_r  <= found_nxt;
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = (state_r == S_RESULT);
  assign out_status      = status_r;
  assign out_found_value = found_r;
  assign out_entry_count = kvt_pkg::OUT_CNT_W'(count_r);

  // Checks
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(tok_vld_w) <= 1)
    else $error("more than one item token in the cell row");

  a_idle_row_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (tok_vld_w == '0))
    else $error("token in the cell row while idle");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= kvt_pkg::CNT_W'(kvt_pkg::ENTRIES))
    else $error("entry count above table size");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == kvt_pkg::ST_FULL))
      |-> (count_r == kvt_pkg::CNT_W'(kvt_pkg::ENTRIES)))
    else $error("full status with free entries");

  a_claim_hits: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_CLAIM) && tail.vld) |-> tail.hit)
    else $error("insert walk found no free cell");

endmodule
